// ===== rtl/lqpi_pkg.sv =====
// Package for the horizontal luma quarter-pel interpolator.
// Holds the sizing constants, tap coefficients and shared types.
// No dependencies.
`default_nettype none

package lqpi_pkg;

  localparam int MAX_BLOCK_WIDTH  = 64;
  localparam int MAX_BLOCK_HEIGHT = 64;

  localparam int PIX_W       = 8;
  localparam int NUM_TAPS    = 8;
  localparam int WIN_TAPS    = NUM_TAPS - 1;
  localparam int NUM_PHASES  = 4;
  localparam int PHASE_W     = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int SAMPLE_W    = 16;
  localparam int ACC_W       = SAMPLE_W + 1;

  // Column counter must reach the widest row end, width + 6.
  localparam int COL_W = $clog2(MAX_BLOCK_WIDTH + WIN_TAPS);
  // Row counter holds at most the height minus one.
  localparam int ROW_W = ($clog2(MAX_BLOCK_HEIGHT) > 0) ? $clog2(MAX_BLOCK_HEIGHT) : 1;
  // Effective height needs room for the maximum itself.
  localparam int HGT_W = ROW_W + 1;

  typedef enum logic [1:0] {
    CFG_FILTER_PHASE = 2'd0,
    CFG_BLOCK_WIDTH  = 2'd1,
    CFG_BLOCK_HEIGHT = 2'd2
  } lqpi_cfg_idx_t;

  typedef logic signed [7:0] lqpi_coef_t;

  // Row p is the tap set of fractional phase p; phase 0 is a plain copy scaled by 64.
  localparam lqpi_coef_t TAP_COEF [NUM_PHASES][NUM_TAPS] = '{
    '{ 8'sd0,  8'sd0,   8'sd0, 8'sd64,  8'sd0,   8'sd0, 8'sd0,  8'sd0},
    '{-8'sd1,  8'sd4, -8'sd10, 8'sd58, 8'sd17,  -8'sd5, 8'sd1,  8'sd0},
    '{-8'sd1,  8'sd4, -8'sd11, 8'sd40, 8'sd40, -8'sd11, 8'sd4, -8'sd1},
    '{ 8'sd0,  8'sd1,  -8'sd5, 8'sd17, 8'sd58, -8'sd10, 8'sd4, -8'sd1}
  };

  typedef logic [NUM_TAPS-1:0][PIX_W-1:0] lqpi_taps_t;

  // Contents of the tap register between the window and the filter.
  typedef struct packed {
    lqpi_taps_t         taps;
    logic [PHASE_W-1:0] phase;
    logic               row_end;
    logic               block_end;
  } lqpi_stage_t;

endpackage

`default_nettype wire

// ===== rtl/lqpi_window.sv =====
// Pixel window, column/row counters and the tap register of the interpolator.
// Depends on lqpi_pkg.
`default_nettype none

module lqpi_window (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [lqpi_pkg::PIX_W-1:0]         in_ref_pixel,
  input  wire logic [lqpi_pkg::PHASE_W-1:0]       filter_phase,
  input  wire logic [lqpi_pkg::CFG_DATA_W-1:0]    block_width,
  input  wire logic [lqpi_pkg::CFG_DATA_W-1:0]    block_height,
  input  wire logic                               stage_take,
  output logic                                    stage_valid,
  output lqpi_pkg::lqpi_stage_t                   stage
);

  logic [lqpi_pkg::PIX_W-1:0] win_r [lqpi_pkg::WIN_TAPS];
  logic [lqpi_pkg::COL_W-1:0] col_r, col_nxt;
  logic [lqpi_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                       stage_valid_r;
  lqpi_pkg::lqpi_stage_t      stage_r, stage_nxt;

  logic                       accept;
  logic                       produce;
  logic                       col_last;
  logic                       row_last;
  logic [lqpi_pkg::COL_W-1:0] w_eff;
  logic [lqpi_pkg::HGT_W-1:0] h_eff;

  // The tap register may reload in the same cycle as it hands its item on.
  assign in_stall    = stage_valid_r && !stage_take;
  assign accept      = in_valid && !in_stall;
  assign stage_valid = stage_valid_r;
  assign stage       = stage_r;

  always_comb begin
    if (int'(block_width) < 4) begin
      w_eff = lqpi_pkg::COL_W'(4);
    end else if (int'(block_width) > lqpi_pkg::MAX_BLOCK_WIDTH) begin
      w_eff = lqpi_pkg::COL_W'(lqpi_pkg::MAX_BLOCK_WIDTH);
    end else begin
      w_eff = lqpi_pkg::COL_W'(block_width);
    end
    if (int'(block_height) < 1) begin
      h_eff = lqpi_pkg::HGT_W'(1);
    end else if (int'(block_height) > lqpi_pkg::MAX_BLOCK_HEIGHT) begin
      h_eff = lqpi_pkg::HGT_W'(lqpi_pkg::MAX_BLOCK_HEIGHT);
    end else begin
      h_eff = lqpi_pkg::HGT_W'(block_height);
    end
  end

  assign produce  = col_r >= lqpi_pkg::COL_W'(lqpi_pkg::WIN_TAPS);
  assign col_last = col_r >= (w_eff + lqpi_pkg::COL_W'(lqpi_pkg::WIN_TAPS - 1));
  assign row_last = ({1'b0, row_r} + lqpi_pkg::HGT_W'(1)) >= h_eff;

  always_comb begin
    col_nxt = col_r + lqpi_pkg::COL_W'(1);
    row_nxt = row_r;
    stage_nxt.phase     = filter_phase;
    stage_nxt.row_end   = 1'b0;
    stage_nxt.block_end = 1'b0;
    for (int i = 0; i < lqpi_pkg::WIN_TAPS; i++) begin
      stage_nxt.taps[i] = win_r[i];
    end
    stage_nxt.taps[lqpi_pkg::NUM_TAPS-1] = in_ref_pixel;
    if (produce && col_last) begin
      col_nxt           = '0;
      stage_nxt.row_end = 1'b1;
      if (row_last) begin
        row_nxt             = '0;
        stage_nxt.block_end = 1'b1;
      end else begin
        row_nxt = row_r + lqpi_pkg::ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= '0;
      row_r         <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (!in_stall) begin
        stage_valid_r <= accept && produce;
      end
    end
  end

  // Window contents are always refilled before they reach a result.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < lqpi_pkg::WIN_TAPS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[lqpi_pkg::WIN_TAPS-1] <= in_ref_pixel;
    end
    if (accept && produce) begin
      stage_r <= stage_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !produce |=> !stage_valid_r)
    else $error("window fill pixel produced a result");

  a_block_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r |-> (!stage_r.block_end || stage_r.row_end))
    else $error("block end without row end");

  a_row_end_clears_col: assert property (@(posedge clk) disable iff (!rst_n)
    accept && produce && col_last |=> col_r == '0)
    else $error("column counter not cleared at row end");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> int'(col_r) <= lqpi_pkg::MAX_BLOCK_WIDTH + lqpi_pkg::WIN_TAPS - 1)
    else $error("column counter beyond widest row");
`endif

endmodule

`default_nettype wire

// ===== rtl/lqpi_filter.sv =====
// Eight-tap filter sum and result register of the interpolator.
// Depends on lqpi_pkg.
`default_nettype none

module lqpi_filter (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  stage_valid,
  input  wire lqpi_pkg::lqpi_stage_t                 stage,
  output logic                                       stage_take,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [lqpi_pkg::SAMPLE_W-1:0]       out_interp_sample,
  output logic                                       out_row_end,
  output logic                                       out_block_end
);

  logic                                 out_valid_r;
  logic signed [lqpi_pkg::SAMPLE_W-1:0] sample_r;
  logic                                 row_end_r;
  logic                                 block_end_r;
  logic signed [lqpi_pkg::ACC_W-1:0]    sums [lqpi_pkg::NUM_PHASES];
  logic signed [lqpi_pkg::ACC_W-1:0]    sum_sel;

  // Each phase has constant coefficients, so every product is a few shifts and adds.
  always_comb begin
    for (int p = 0; p < lqpi_pkg::NUM_PHASES; p++) begin
      sums[p] = '0;
      for (int i = 0; i < lqpi_pkg::NUM_TAPS; i++) begin
        sums[p] = sums[p] + lqpi_pkg::TAP_COEF[p][i] * signed'({1'b0, stage.taps[i]});
      end
    end
    sum_sel = sums[stage.phase];
  end

  assign stage_take        = !out_valid_r || !out_stall;
  assign out_valid         = out_valid_r;
  assign out_interp_sample = sample_r;
  assign out_row_end       = row_end_r;
  assign out_block_end     = block_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_take) begin
      out_valid_r <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take && stage_valid) begin
      sample_r    <= sum_sel[lqpi_pkg::SAMPLE_W-1:0];
      row_end_r   <= stage.row_end;
      block_end_r <= stage.block_end;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/luma_qpel_horizontal_interp.sv =====
// Top level of the horizontal 8-tap luma quarter-pel interpolator.
// Depends on lqpi_pkg, lqpi_window and lqpi_filter.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  in_ref_pixel (8 bits)
//   out_     output     out_valid/out_stall out_interp_sample (16 bits signed),
//                                          out_row_end, out_block_end
//   cfg_     input      cfg_valid/cfg_ready cfg_index (2 bits), cfg_wdata (7 bits)
//
// One pixel is accepted per cycle while in_stall is low. A pixel that completes
// a tap group loads its taps into the tap register when it is accepted; its
// sample then moves on into the result register, where the receiver takes it.
// The window and the filter are one pass of logic each, so throughput is one
// item per cycle while out_stall stays low.
// Reset (rst_n low, synchronous) empties both registers, clears the column and
// row counters and restores phase 0, width 64 and height 64.
// in_stall rises only when both registers hold items and out_stall is high.
`default_nettype none

module luma_qpel_horizontal_interp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [lqpi_pkg::PIX_W-1:0]           in_ref_pixel,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [lqpi_pkg::SAMPLE_W-1:0]      out_interp_sample,
  output logic                                      out_row_end,
  output logic                                      out_block_end,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [1:0]                           cfg_index,
  input  wire logic [lqpi_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [lqpi_pkg::PHASE_W-1:0]    filter_phase_r;
  logic [lqpi_pkg::CFG_DATA_W-1:0] block_width_r;
  logic [lqpi_pkg::CFG_DATA_W-1:0] block_height_r;

  logic                  stage_valid;
  logic                  stage_take;
  lqpi_pkg::lqpi_stage_t stage;

  // Register writes are always taken; software writes only while the block is idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_phase_r <= '0;
      block_width_r  <= lqpi_pkg::CFG_DATA_W'(64);
      block_height_r <= lqpi_pkg::CFG_DATA_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (lqpi_pkg::lqpi_cfg_idx_t'(cfg_index))
        lqpi_pkg::CFG_FILTER_PHASE: filter_phase_r <= cfg_wdata[lqpi_pkg::PHASE_W-1:0];
        lqpi_pkg::CFG_BLOCK_WIDTH:  block_width_r  <= cfg_wdata;
        lqpi_pkg::CFG_BLOCK_HEIGHT: block_height_r <= cfg_wdata;
        default: ; // The unused index is ignored.
      endcase
    end
  end

  // Window and counters: turns the pixel stream into 8-tap groups with row and
  // block flags, and holds them in the tap register.
  lqpi_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ref_pixel (in_ref_pixel),
    .filter_phase (filter_phase_r),
    .block_width  (block_width_r),
    .block_height (block_height_r),
    .stage_take   (stage_take),
    .stage_valid  (stage_valid),
    .stage        (stage)
  );

  // Filter: weighted sum of the taps for the captured phase, into the result register.
  lqpi_filter u_filter (
    .clk               (clk),
    .rst_n             (rst_n),
    .stage_valid       (stage_valid),
    .stage             (stage),
    .stage_take        (stage_take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_interp_sample (out_interp_sample),
    .out_row_end       (out_row_end),
    .out_block_end     (out_block_end)
  );

endmodule

`default_nettype wire

// ===== tb/lqpi_checker.sv =====
// Result checker for the horizontal luma quarter-pel interpolator.
// Watches the pixel, result and register write channels, predicts every sample
// and compares. Depends on lqpi_pkg for widths and register indexes.
module lqpi_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [lqpi_pkg::PIX_W-1:0]          in_ref_pixel,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [lqpi_pkg::SAMPLE_W-1:0] out_interp_sample,
  input  logic                                out_row_end,
  input  logic                                out_block_end,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [lqpi_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic [31:0]                         pending,
  output logic [31:0]                         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import lqpi_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       row_end;
    logic                       block_end;
  } qpel_result_t;

  // Tap weights per fractional phase; phase 0 is a copy of the aligned pixel times 64.
  localparam int QPEL_WEIGHT [4][8] = '{
    '{ 0, 0,   0, 64,  0,   0, 0,  0},
    '{-1, 4, -10, 58, 17,  -5, 1,  0},
    '{-1, 4, -11, 40, 40, -11, 4, -1},
    '{ 0, 1,  -5, 17, 58, -10, 4, -1}
  };

  logic [PIX_W-1:0]      window [WIN_TAPS];
  logic [6:0]            col_cnt;
  logic [5:0]            row_cnt;
  logic [PHASE_W-1:0]    phase_reg;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  qpel_result_t          expected_q [$];
  int unsigned           mismatches;

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int row_length();
    if (width_reg < 4) return 4;
    if (width_reg > MAX_BLOCK_WIDTH) return MAX_BLOCK_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int row_total();
    if (height_reg < 1) return 1;
    if (height_reg > MAX_BLOCK_HEIGHT) return MAX_BLOCK_HEIGHT;
    return int'(height_reg);
  endfunction

  function automatic void take_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_FILTER_PHASE: phase_reg = val[PHASE_W-1:0];
      CFG_BLOCK_WIDTH:  width_reg = val;
      CFG_BLOCK_HEIGHT: height_reg = val;
      default: ;
    endcase
  endfunction

  // Shifts the pixel into the window and queues the sample it completes, if any.
  function automatic void filter_pixel(input logic [PIX_W-1:0] px);
    logic [PIX_W-1:0] taps [NUM_TAPS];
    int               acc;
    qpel_result_t     res;
    for (int i = 0; i < WIN_TAPS; i++) taps[i] = window[i];
    taps[NUM_TAPS-1] = px;
    for (int i = 0; i < WIN_TAPS - 1; i++) window[i] = window[i+1];
    window[WIN_TAPS-1] = px;
    if (col_cnt < WIN_TAPS) begin
      col_cnt++;
    end else begin
      acc = 0;
      for (int i = 0; i < NUM_TAPS; i++) acc += QPEL_WEIGHT[phase_reg][i] * int'(taps[i]);
      res.sample    = acc[SAMPLE_W-1:0];
      res.row_end   = 1'b0;
      res.block_end = 1'b0;
      if (int'(col_cnt) >= row_length() + 6) begin
        res.row_end = 1'b1;
        col_cnt = '0;
        if (int'(row_cnt) + 1 >= row_total()) begin
          res.block_end = 1'b1;
          row_cnt = '0;
        end else begin
          row_cnt++;
        end
      end else begin
        col_cnt++;
      end
      expected_q.push_back(res);
    end
  endfunction

  task automatic compare_sample();
    qpel_result_t want;
    if (expected_q.size() == 0) begin
      note_mismatch($sformatf("sample %0d arrived with nothing predicted", out_interp_sample));
    end else begin
      want = expected_q.pop_front();
      if (out_interp_sample !== want.sample)
        note_mismatch($sformatf("sample %0d, predicted %0d", out_interp_sample, want.sample));
      if (out_row_end !== want.row_end)
        note_mismatch($sformatf("row end %b, predicted %b", out_row_end, want.row_end));
      if (out_block_end !== want.block_end)
        note_mismatch($sformatf("block end %b, predicted %b", out_block_end, want.block_end));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_TAPS; i++) window[i] = '0;
      col_cnt    = '0;
      row_cnt    = '0;
      phase_reg  = '0;
      width_reg  = 7'd64;
      height_reg = 7'd64;
      expected_q.delete();
    end else begin
      // A result always trails its pixel, so compare before queuing the new prediction.
      if (cfg_valid && cfg_ready) take_write(cfg_index, cfg_wdata);
      if (out_valid && !out_stall) compare_sample();
      if (in_valid && !in_stall) filter_pixel(in_ref_pixel);
    end
    pending    <= expected_q.size();
    fail_count <= mismatches;
  end

  initial mismatches = 0;

endmodule

// ===== tb/tb_top.sv =====
// Top of the testbench for the horizontal luma quarter-pel interpolator.
// Drives pixels and register writes, stalls the result side, and gives the
// verdict from the count kept by lqpi_checker. Depends on lqpi_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lqpi_pkg::*;

  // Fractional phase codes as written to the filter phase register.
  localparam logic [1:0] PHASE_FULL          = 2'd0;
  localparam logic [1:0] PHASE_QUARTER       = 2'd1;
  localparam logic [1:0] PHASE_HALF          = 2'd2;
  localparam logic [1:0] PHASE_THREE_QUARTER = 2'd3;
  // An index outside the register list; the block is expected to ignore it.
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

  localparam int PIXEL_TARGET  = 1750;
  // A pixel passes the tap register, then the result register; the settle
  // cycles let a filling pixel finish before the registers change.
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 60;
  localparam int MAX_CHUNK     = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_ref_pixel;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [SAMPLE_W-1:0] out_interp_sample;
  logic                  out_row_end;
  logic                  out_block_end;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic [31:0]           pending;
  logic [31:0]           fail_count;

  // hold_req passes from the pixel process to the result process; the rest each serve one process.
  bit          hold_req;
  bit          tx_burst;
  bit          rx_burst;
  int unsigned pixels_sent;

  // The testbench's own view of the registers, used only to size the stimulus.
  logic [CFG_DATA_W-1:0] width_now;
  logic [CFG_DATA_W-1:0] height_now;

  luma_qpel_horizontal_interp dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_ref_pixel      (in_ref_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_interp_sample (out_interp_sample),
    .out_row_end       (out_row_end),
    .out_block_end     (out_block_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  lqpi_checker sample_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_ref_pixel      (in_ref_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_interp_sample (out_interp_sample),
    .out_row_end       (out_row_end),
    .out_block_end     (out_block_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .pending           (pending),
    .fail_count        (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block wedges or drops samples.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Half the pixels are biased to the rails so that the filter sums hit their
  // extremes; the rest are uniform so that every bit toggles.
  function automatic logic [PIX_W-1:0] draw_pixel();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int clamp_width(input logic [CFG_DATA_W-1:0] v);
    if (v < 4) return 4;
    if (v > MAX_BLOCK_WIDTH) return MAX_BLOCK_WIDTH;
    return int'(v);
  endfunction

  function automatic int clamp_height(input logic [CFG_DATA_W-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_BLOCK_HEIGHT) return MAX_BLOCK_HEIGHT;
    return int'(v);
  endfunction

  // Offers one pixel after a random gap (none in a burst) and holds it until the block takes it.
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_ref_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // Leaves cfg_valid high; the caller lowers it once the batch of writes is done,
  // so that back-to-back writes never lower and raise it in the same step.
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_BLOCK_WIDTH) width_now = val;
    if (idx == CFG_BLOCK_HEIGHT) height_now = val;
  endtask

  // Stops offering pixels and waits for every predicted sample, then lets any
  // filling pixel still in flight settle, so the block is idle for a write.
  task automatic drain_samples();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Picks new register values for one stretch of random traffic.
  task automatic random_settings();
    int pick;
    if ($urandom_range(0, 3) != 0) write_reg(CFG_FILTER_PHASE, CFG_DATA_W'($urandom_range(0, 127)));
    if ($urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)       write_reg(CFG_BLOCK_WIDTH, CFG_DATA_W'($urandom_range(0, 12)));
      else if (pick < 9)  write_reg(CFG_BLOCK_WIDTH, CFG_DATA_W'($urandom_range(13, 127)));
      else if ($urandom_range(0, 1) == 0) write_reg(CFG_BLOCK_WIDTH, 7'd0);
      else                write_reg(CFG_BLOCK_WIDTH, 7'd127);
    end
    if ($urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, 9);
      // Wide rows get few rows, so a whole block stays short.
      if (clamp_width(width_now) > 16 || pick < 8)
        write_reg(CFG_BLOCK_HEIGHT, CFG_DATA_W'($urandom_range(0, 4)));
      else if (pick == 8)
        write_reg(CFG_BLOCK_HEIGHT, ($urandom_range(0, 1) == 0) ? 7'd0 : 7'd127);
      else
        write_reg(CFG_BLOCK_HEIGHT, CFG_DATA_W'($urandom_range(5, 64)));
    end
    if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom_range(0, 127)));
    cfg_valid <= 1'b0;
  endtask

  // Result side: a random stall before each sample, stretches without stalls,
  // and once a long hold so that both pipeline registers fill and in_stall rises.
  initial begin
    int wait_cycles;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      wait_cycles = rx_burst ? 0 : $urandom_range(0, 3);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
    end
  end

  initial begin
    logic [PIX_W-1:0] row_lo [11];
    logic [PIX_W-1:0] row_hi [11];
    int  chunk;
    int  block_pixels;
    int  guard;
    bit  hold_done;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_ref_pixel <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_FILTER_PHASE;
    cfg_wdata    <= '0;
    hold_req     = 1'b0;
    tx_burst     = 1'b0;
    rx_burst     = 1'b0;
    pixels_sent  = 0;
    hold_done    = 1'b0;
    width_now    = 7'd64;
    height_now   = 7'd64;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Half-pel rows of width four (written as zero, so saturated up). The first
    // sample of the first row has 255 on every negative tap and nothing else,
    // the lowest sum; the second row does the same for the positive taps.
    row_lo = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255,
               8'd255, 8'd255, 8'd255};
    row_hi = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0,
               8'd0, 8'd0, 8'd0};
    write_reg(CFG_FILTER_PHASE, 7'(PHASE_HALF));
    write_reg(CFG_BLOCK_WIDTH, 7'd0);
    write_reg(CFG_BLOCK_HEIGHT, 7'd2);
    cfg_valid <= 1'b0;
    foreach (row_lo[i]) send_pixel(row_lo[i]);
    foreach (row_hi[i]) send_pixel(row_hi[i]);
    drain_samples();

    // Registers changed in the middle of a row: with width five the column
    // counter stands past the end for width four, so after the rewrite the very
    // next sample must close the row, and with height one the block too.
    write_reg(CFG_FILTER_PHASE, 7'(PHASE_FULL));
    write_reg(CFG_BLOCK_WIDTH, 7'd5);
    write_reg(CFG_BLOCK_HEIGHT, 7'd127);
    cfg_valid <= 1'b0;
    repeat (11) send_pixel(draw_pixel());
    drain_samples();
    write_reg(CFG_BLOCK_WIDTH, 7'd0);
    write_reg(CFG_BLOCK_HEIGHT, 7'd1);
    cfg_valid <= 1'b0;
    send_pixel(draw_pixel());
    drain_samples();

    // Random traffic: mostly whole blocks at small sizes, now and then a block
    // cut short so that the next settings land on counters in mid-block.
    while (pixels_sent < PIXEL_TARGET) begin
      if (!hold_done && pixels_sent >= PIXEL_TARGET / 2) begin
        // One full-width row offered without gaps while the result side holds off.
        write_reg(CFG_FILTER_PHASE, 7'(PHASE_THREE_QUARTER));
        write_reg(CFG_BLOCK_WIDTH, 7'd64);
        write_reg(CFG_BLOCK_HEIGHT, 7'd1);
        cfg_valid <= 1'b0;
        hold_done = 1'b1;
        hold_req  = 1'b1;
        tx_burst  = 1'b1;
        chunk     = (MAX_BLOCK_WIDTH + WIN_TAPS);
      end else begin
        random_settings();
        tx_burst     = ($urandom_range(0, 3) == 0);
        block_pixels = (clamp_width(width_now) + WIN_TAPS) * clamp_height(height_now);
        chunk        = block_pixels;
        if (block_pixels > MAX_CHUNK || $urandom_range(0, 7) == 0)
          chunk = $urandom_range(1, (block_pixels > MAX_CHUNK) ? MAX_CHUNK : block_pixels);
      end
      repeat (chunk) send_pixel(draw_pixel());
      drain_samples();
    end

    // Every pixel is in; wait for the last samples, then watch a little longer
    // for anything the block sends that was never predicted.
    in_valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < 5000);
    if (pending != 0) begin
      $display("CHECK FAILED");
    end else begin
      repeat (SETTLE_CYCLES * 2) @(posedge clk);
      if (fail_count == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
    end
    $finish;
  end

endmodule
